// ===== rtl/packet_loss_jitter_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// packet_loss_jitter_monitor_macros.svh
// Assertion helper macros shared by the packet loss / jitter monitor RTL.
// ----------------------------------------------------------------------------
`ifndef PACKET_LOSS_JITTER_MONITOR_MACROS_SVH
`define PACKET_LOSS_JITTER_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plj assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PLJ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plj assertion failed");

`endif

// ===== rtl/plj_pkg.sv =====
// ----------------------------------------------------------------------------
// plj_pkg
// Types and constants for the packet loss / jitter monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package plj_pkg;

    // Divider geometry: two quotient bits per cycle
    localparam int DIV_W     = 52;
    localparam int DVSR_W    = 32;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PACKAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQUENCE = 1'd1;

    localparam logic [15:0] PACKAGE_SIZE_RST = 16'd1024;

    // Jitter saturation bounds (signed Q.16, 48 bits)
    localparam logic signed [47:0] JIT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] JIT_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [31:0] seq_number;
        logic [31:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        byte_total;
        logic [31:0]        last_seq;
        logic [31:0]        lost_total;
        logic signed [47:0] jitter_value;
        logic               in_order;
        logic               session_end;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic             rem_nz;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/plj_div.sv =====
// ----------------------------------------------------------------------------
// plj_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "packet_loss_jitter_monitor_macros.svh"

module plj_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire plj_pkg::t_div_req i_req,
    output plj_pkg::t_div_rsp      o_rsp
);

    logic [plj_pkg::DVSR_W-1:0] r_rem;
    logic [plj_pkg::DIV_W-1:0]  r_quo;
    logic [plj_pkg::DVSR_W-1:0] r_dvsr;
    logic [plj_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [plj_pkg::DVSR_W:0]   w_t1, w_t2;
    logic                       w_ge1, w_ge2;
    logic [plj_pkg::DVSR_W-1:0] w_rem1, w_rem2;
    logic                       w_last;

    // Two dependent compare/subtract steps
    always_comb begin
        w_t1   = {r_rem, r_quo[plj_pkg::DIV_W-1]};
        w_ge1  = (w_t1 >= {1'b0, r_dvsr});
        w_rem1 = w_ge1 ? plj_pkg::DVSR_W'(w_t1 - {1'b0, r_dvsr})
                       : plj_pkg::DVSR_W'(w_t1);
        w_t2   = {w_rem1, r_quo[plj_pkg::DIV_W-2]};
        w_ge2  = (w_t2 >= {1'b0, r_dvsr});
        w_rem2 = w_ge2 ? plj_pkg::DVSR_W'(w_t2 - {1'b0, r_dvsr})
                       : plj_pkg::DVSR_W'(w_t2);
    end

    assign w_last = (r_cnt == plj_pkg::CNT_W'(plj_pkg::DIV_STEPS - 1));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + plj_pkg::CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[plj_pkg::DIV_W-3:0], w_ge1, w_ge2};
            r_rem <= w_rem2;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.rem_nz   = |r_rem;

    `PLJ_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_req.start, !r_busy)
    `PLJ_ASSERT_NXT(a_done_after_last, i_clk, i_rst_n, r_busy && w_last && !i_req.start, r_done)
    `PLJ_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)

endmodule

`default_nettype wire

// ===== rtl/packet_loss_jitter_monitor.sv =====
// ----------------------------------------------------------------------------
// packet_loss_jitter_monitor
// Byte total, sequence loss count and running jitter per received packet.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
//  An in-order packet is handled by two passes through the shared
//  2-bit-per-cycle divider (26 iterations each) and eight sequencer
//  steps. A skipped packet goes from UPD straight to PUB.
//  One packet is in flight at a time.
//  Reset is synchronous, active low; it clears all running state.
//  A result waits in the output register; the next packet may be taken
//  meanwhile, but it is published only after that result is transferred.
// ----------------------------------------------------------------------------
`default_nettype none
`include "packet_loss_jitter_monitor_macros.svh"

module packet_loss_jitter_monitor (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire plj_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output plj_pkg::t_out_item                o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [plj_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                  i_cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UPD   = 4'd1;
    localparam logic [3:0] ST_NCALC = 4'd2;
    localparam logic [3:0] ST_D1S   = 4'd3;
    localparam logic [3:0] ST_D1W   = 4'd4;
    localparam logic [3:0] ST_XJ    = 4'd5;
    localparam logic [3:0] ST_D2S   = 4'd6;
    localparam logic [3:0] ST_D2W   = 4'd7;
    localparam logic [3:0] ST_ADD   = 4'd8;
    localparam logic [3:0] ST_PUB   = 4'd9;

    logic [3:0]  r_state, n_state;

    logic [15:0] r_pkg_size;
    logic [31:0] r_max_seq;

    logic [31:0]        r_seq, r_time, r_n;
    logic [31:0]        r_prev_seq, r_lost, r_prev_time;
    logic [63:0]        r_bytes;
    logic signed [47:0] r_jitter;
    logic signed [51:0] r_acc;
    logic               r_hit, r_neg;
    logic               r_out_valid;

    plj_pkg::t_div_req w_req;
    plj_pkg::t_div_rsp w_rsp;

    logic               w_in_acc, w_can_pub;
    logic signed [32:0] w_d;
    logic signed [51:0] w_x;
    logic [51:0]        w_mag, w_q_mag;
    logic signed [52:0] w_sum;
    logic signed [47:0] w_sat;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_can_pub  = !r_out_valid || i_out_ready;

    // Arithmetic around the divider
    always_comb begin
        w_d     = $signed({1'b0, r_time}) - $signed({1'b0, r_prev_time});
        w_x     = $signed({{3{w_d[32]}}, w_d, 16'd0}) - $signed(w_rsp.quotient);
        w_mag   = r_acc[51] ? 52'(-r_acc) : 52'(r_acc);
        w_q_mag = w_rsp.quotient + {51'd0, w_rsp.rem_nz};
        w_sum   = $signed({{5{r_jitter[47]}}, r_jitter}) + $signed({r_acc[51], r_acc});
        if (w_sum[52:47] == 6'b000000 || w_sum[52:47] == 6'b111111) begin
            w_sat = w_sum[47:0];
        end else begin
            w_sat = w_sum[52] ? plj_pkg::JIT_MIN : plj_pkg::JIT_MAX;
        end
    end

    // Divider requests: t*65536/n first, then |a|/n
    always_comb begin
        w_req.start    = ((r_state == ST_D1S) && (r_n != 32'd0)) || (r_state == ST_D2S);
        w_req.dividend = (r_state == ST_D1S) ? {4'd0, r_time, 16'd0} : w_mag;
        w_req.divisor  = r_n;
    end

    plj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_UPD;
            ST_UPD:   n_state = r_hit ? ST_NCALC : ST_PUB;
            ST_NCALC: n_state = ST_D1S;
            ST_D1S:   n_state = (r_n != 32'd0) ? ST_D1W : ST_PUB;
            ST_D1W:   if (w_rsp.done) n_state = ST_XJ;
            ST_XJ:    n_state = ST_D2S;
            ST_D2S:   n_state = ST_D2W;
            ST_D2W:   if (w_rsp.done) n_state = ST_ADD;
            ST_ADD:   n_state = ST_PUB;
            ST_PUB:   if (w_can_pub) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control, configuration and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pkg_size  <= plj_pkg::PACKAGE_SIZE_RST;
            r_max_seq   <= '0;
            r_prev_seq  <= '0;
            r_lost      <= '0;
            r_jitter    <= '0;
            r_prev_time <= '0;
            r_bytes     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    plj_pkg::REG_PACKAGE_SIZE: r_pkg_size <= i_cfg_data[15:0];
                    plj_pkg::REG_MAX_SEQUENCE: r_max_seq  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_bytes <= r_bytes + {48'd0, r_pkg_size};
            end

            // Gap accounting on an in-order packet
            if (r_state == ST_UPD && r_hit) begin
                r_lost     <= r_lost + (r_seq - r_prev_seq - 32'd1);
                r_prev_seq <= r_seq;
            end

            if (r_state == ST_D1S && r_n == 32'd0) begin
                r_prev_time <= r_time;
            end

            if (r_state == ST_ADD) begin
                r_jitter    <= w_sat;
                r_prev_time <= r_time;
            end

            // Output register
            if (r_state == ST_PUB && w_can_pub) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_seq  <= i_in_data.seq_number;
            r_time <= i_in_data.elapsed_ms;
            r_hit  <= (i_in_data.seq_number > r_prev_seq);
        end
        if (r_state == ST_NCALC) begin
            r_n <= r_seq - r_lost;
        end
        if (r_state == ST_D1W && w_rsp.done) begin
            r_acc <= w_x;
        end
        if (r_state == ST_XJ) begin
            r_acc <= r_acc - $signed({{4{r_jitter[47]}}, r_jitter});
        end
        if (r_state == ST_D2S) begin
            r_neg <= r_acc[51];
        end
        // Floor division: a negative dividend rounds away from zero
        if (r_state == ST_D2W && w_rsp.done) begin
            r_acc <= r_neg ? -$signed(w_q_mag) : $signed(w_rsp.quotient);
        end
        if (r_state == ST_PUB && w_can_pub) begin
            o_out_data.byte_total   <= r_bytes;
            o_out_data.last_seq     <= r_prev_seq;
            o_out_data.lost_total   <= r_lost;
            o_out_data.jitter_value <= r_jitter;
            o_out_data.in_order     <= r_hit;
            o_out_data.session_end  <= r_hit && (r_max_seq != 32'd0) && (r_seq == r_max_seq);
        end
    end

    assign o_out_valid = r_out_valid;

    `PLJ_ASSERT_IMP(a_idle_div_free, i_clk, i_rst_n, w_in_acc, !w_rsp.busy)
    `PLJ_ASSERT_IMP(a_start_state, i_clk, i_rst_n, w_req.start, (r_state == ST_D1S) || (r_state == ST_D2S))
    `PLJ_ASSERT_IMP(a_done_state, i_clk, i_rst_n, w_rsp.done, (r_state == ST_D1W) || (r_state == ST_D2W))

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: packet loss / jitter monitor regression
// Feeds packet streams through the valid/ready input with random gaps and
// stalls the result side at random. Each transfer is predicted by an
// independent bit-accurate copy of the byte/loss/jitter bookkeeping and
// checked field by field. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned STALL_LIMIT = 4000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    plj_pkg::t_in_item    i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [plj_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    plj_pkg::t_out_item   o_out_data;

    packet_loss_jitter_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the registers and running state
    logic [15:0] pkt_bytes = plj_pkg::PACKAGE_SIZE_RST;
    logic [31:0] seq_limit = '0;
    logic [31:0] high_seq  = '0;
    logic [31:0] lost_pkts = '0;
    logic [31:0] prev_ms   = '0;
    logic [63:0] byte_count = '0;
    longint      jitter_q16 = 0;

    plj_pkg::t_in_item    pending_pkts[$];
    plj_pkg::t_out_item   expected_stats[$];

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned in_order_seen  = 0;
    int unsigned session_ends   = 0;
    int unsigned reg_writes     = 0;
    int unsigned fail_count     = 0;

    int unsigned in_wait  = 0;
    int unsigned out_wait = 0;
    bit          in_quiet  = 1'b0;
    bit          out_quiet = 1'b0;
    int unsigned idle_cycles = 0;

    // Packet stream generator state
    logic [31:0] gen_seq = '0;
    logic [31:0] gen_ms  = '0;

    // floor division for a positive divisor
    function automatic longint floor_quotient(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Bookkeeping for one received packet; returns the expected statistics
    function automatic plj_pkg::t_out_item account_packet(plj_pkg::t_in_item pkt);
        plj_pkg::t_out_item res;
        logic [31:0] span;
        logic [63:0] t_scaled;
        longint      avg, delta, x, den, nj;
        res = '0;
        byte_count = byte_count + {48'd0, pkt_bytes};
        if (pkt.seq_number > high_seq) begin
            res.in_order = 1'b1;
            lost_pkts = lost_pkts + (pkt.seq_number - high_seq - 32'd1);
            high_seq  = pkt.seq_number;
            span = pkt.seq_number - lost_pkts;
            if (span != 32'd0) begin
                t_scaled = {16'd0, pkt.elapsed_ms, 16'd0};
                avg   = longint'(t_scaled / {32'd0, span});
                delta = longint'({32'd0, pkt.elapsed_ms}) - longint'({32'd0, prev_ms});
                x     = delta * 64'sd65536 - avg;
                den   = longint'({32'd0, span});
                nj    = jitter_q16 + floor_quotient(x - jitter_q16, den);
                if (nj > longint'(plj_pkg::JIT_MAX))
                    nj = longint'(plj_pkg::JIT_MAX);
                if (nj < longint'(plj_pkg::JIT_MIN))
                    nj = longint'(plj_pkg::JIT_MIN);
                jitter_q16 = nj;
            end
            prev_ms = pkt.elapsed_ms;
            res.session_end = (seq_limit != 32'd0) && (pkt.seq_number == seq_limit);
        end
        res.byte_total   = byte_count;
        res.last_seq     = high_seq;
        res.lost_total   = lost_pkts;
        res.jitter_value = jitter_q16[47:0];
        return res;
    endfunction

    function automatic int unsigned draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(plj_pkg::t_out_item got);
        plj_pkg::t_out_item want;
        if (expected_stats.size() == 0) begin
            $error("result with no packet pending: last_seq 0x%0h", got.last_seq);
            fail_count++;
        end else begin
            want = expected_stats.pop_front();
            results_checked++;
            if (want.in_order)
                in_order_seen++;
            if (want.session_end)
                session_ends++;
            compare_field("byte_total", want.byte_total, got.byte_total);
            compare_field("last_seq", want.last_seq, got.last_seq);
            compare_field("lost_total", want.lost_total, got.lost_total);
            compare_field("jitter_value", want.jitter_value, got.jitter_value);
            compare_field("in_order", want.in_order, got.in_order);
            compare_field("session_end", want.session_end, got.session_end);
        end
    endtask

    // Packet driver: one transfer at a time, random gap after each
    always @(posedge i_clk) begin : packet_driver
        bit stalled;
        stalled = i_in_valid && !o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_stats.push_back(account_packet(i_in_data));
                items_accepted++;
            end
            if (!stalled) begin
                if (in_wait != 0) begin
                    i_in_valid <= 1'b0;
                    in_wait    <= in_wait - 1;
                end else if (pending_pkts.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_pkts.pop_front();
                    if ($urandom_range(0, 29) == 0)
                        in_quiet = !in_quiet;
                    in_wait <= draw_wait(in_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer, then stalls for a random time
    always @(posedge i_clk) begin : result_monitor
        int unsigned hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && i_out_ready) begin
            check_result(o_out_data);
            if ($urandom_range(0, 29) == 0)
                out_quiet = !out_quiet;
            hold = draw_wait(out_quiet);
            out_wait    <= hold;
            i_out_ready <= (hold == 0);
        end else if (out_wait != 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= (out_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: no transfer for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [plj_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            plj_pkg::REG_PACKAGE_SIZE: pkt_bytes = val[15:0];
            plj_pkg::REG_MAX_SEQUENCE: seq_limit = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic queue_packet(logic [31:0] seq, logic [31:0] ms);
        plj_pkg::t_in_item pkt;
        pkt.seq_number = seq;
        pkt.elapsed_ms = ms;
        pending_pkts.push_back(pkt);
        items_queued++;
    endtask

    // Mostly in-order traffic with gaps, repeats, stale packets and clock jumps
    task automatic queue_traffic(int count);
        int unsigned pick;
        logic [31:0] seq, ms;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            seq  = gen_seq + 32'd1;
            ms   = gen_ms + $urandom_range(0, 300);
            if (pick >= 94) begin
                // noise at or below the accepted sequence
                seq = $urandom_range(0, gen_seq);
                ms  = $urandom();
            end else if (pick >= 86) begin
                // repeated or slightly stale packet
                seq = gen_seq - $urandom_range(0, (gen_seq < 32'd16) ? gen_seq : 32'd16);
            end else if (pick >= 78) begin
                // elapsed time jumps, usually backwards
                ms = pick[0] ? $urandom() : gen_ms - $urandom_range(0, 5000);
            end else if (pick >= 66) begin
                seq = gen_seq + $urandom_range(2, 1000);
            end
            if (seq > gen_seq) begin
                gen_seq = seq;
                gen_ms  = ms;
            end
            queue_packet(seq, ms);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (items_accepted != items_queued || expected_stats.size() != 0);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first packet, time extremes, repeats, gap, session end
        write_reg(plj_pkg::REG_PACKAGE_SIZE, 32'd65535);
        write_reg(plj_pkg::REG_MAX_SEQUENCE, 32'd10);
        queue_packet(32'd0, 32'd0);
        queue_packet(32'd1, 32'd0);
        queue_packet(32'd2, 32'hFFFF_FFFF);
        queue_packet(32'd3, 32'd0);
        queue_packet(32'd3, 32'd5);
        queue_packet(32'd2, 32'd7);
        queue_packet(32'd7, 32'd100);
        queue_packet(32'd10, 32'h8000_0000);
        queue_packet(32'd11, 32'h8000_0001);
        queue_packet(32'd12, 32'hFFFF_FFFF);
        queue_packet(32'd13, 32'hFFFF_FFFF);
        queue_packet(32'd20, 32'h0000_1234);
        gen_seq = 32'd20;
        gen_ms  = 32'h0000_1234;
        wait_drained();

        // Smallest packet size, no session limit
        write_reg(plj_pkg::REG_PACKAGE_SIZE, 32'd1);
        write_reg(plj_pkg::REG_MAX_SEQUENCE, 32'd0);
        queue_traffic(100);
        wait_drained();

        // Session limit a little ahead of the stream
        write_reg(plj_pkg::REG_PACKAGE_SIZE, $urandom_range(2, 65534));
        write_reg(plj_pkg::REG_MAX_SEQUENCE, gen_seq + $urandom_range(3, 40));
        queue_traffic(100);
        wait_drained();

        write_reg(plj_pkg::REG_PACKAGE_SIZE, $urandom_range(1, 65535));
        write_reg(plj_pkg::REG_MAX_SEQUENCE, 32'hFFFF_FFFF);
        queue_traffic(100);
        wait_drained();

        // Jump to the top of the sequence space and finish on the last number
        write_reg(plj_pkg::REG_PACKAGE_SIZE, 32'd65535);
        gen_seq = 32'hF000_0000 | ($urandom() & 32'h0FF0_0000);
        gen_ms  = gen_ms + 32'd50;
        queue_packet(gen_seq, gen_ms);
        queue_traffic(90);
        queue_packet(32'hFFFF_FFFE, 32'h0000_0010);
        queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_packet(32'hFFFF_FFFF, 32'd0);
        queue_packet(32'd0, 32'd0);
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Summary: %0d packets, %0d register writes; %0d in order, %0d skipped,",
                 items_accepted, reg_writes, in_order_seen, results_checked - in_order_seen);
        $display("         %0d session ends, %0d results checked", session_ends,
                 results_checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
